// ----- design/cau_pkg.sv -----
// Shared types and constants of the complex arithmetic unit.
package cau_pkg;

  localparam int FieldW     = 32;
  localparam int FuncW      = 3;
  localparam int QueueDepth = 4;

  // Operation codes as they arrive on the input channel.
  localparam logic [FuncW-1:0] FUNC_ADD = 3'd0;
  localparam logic [FuncW-1:0] FUNC_SUB = 3'd1;
  localparam logic [FuncW-1:0] FUNC_MUL = 3'd2;
  localparam logic [FuncW-1:0] FUNC_DIV = 3'd3;
  localparam logic [FuncW-1:0] FUNC_EQ  = 3'd4;
  localparam logic [FuncW-1:0] FUNC_NE  = 3'd5;

  // Operation class as decoded by the front part.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_CMP  = 3'd5
  } op_e;

  localparam int OpW = 3;

  typedef struct packed {
    logic [FuncW-1:0]         func;
    logic signed [FieldW-1:0] a_re;
    logic signed [FieldW-1:0] a_im;
    logic signed [FieldW-1:0] b_re;
    logic signed [FieldW-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [FieldW-1:0] res_re;
    logic signed [FieldW-1:0] res_im;
    logic                     compare_true;
    logic                     div_by_zero;
    logic                     saturated;
  } out_t;

endpackage

// ----- design/complex_arithmetic_unit_top.sv -----
// Top level of the complex arithmetic unit: front decode, queue and execution back end.
// Add, subtract, multiply, compare and zero-divisor transactions pass through the front register,
// queue, product stage and output register; they sustain one transaction per cycle while
// neither a divide nor a receiver stall holds the back end. A divide runs a bit-serial divider
// on the default Q16.16 format and holds the back end until its result is written out.
// Reset clears only valid and busy flags and queue pointers and count, not the data registers.
module complex_arithmetic_unit_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cau_pkg::out_t out_data_o
);

  // A queued transaction carries the decoded operation, the compare outcome and the
  // four operands at DATA_WIDTH bits.
  localparam int QW = cau_pkg::OpW + 1 + 4 * DATA_WIDTH;

  logic                         push_w, full_w, pop_w, empty_w;
  cau_pkg::op_e                 fr_op_w;
  logic                         fr_cmp_w;
  logic signed [DATA_WIDTH-1:0] fr_ar_w, fr_ai_w, fr_br_w, fr_bi_w;
  logic [QW-1:0]                q_in_w, q_out_w;
  logic signed [DATA_WIDTH-1:0] bk_ar_w, bk_ai_w, bk_br_w, bk_bi_w;
  logic                         bk_cmp_w;
  logic [cau_pkg::OpW-1:0]      bk_op_bits_w;

  // The front part registers each transaction and decodes its operation. It stalls
  // only when its register is full and the queue cannot take the entry.
  cau_front #(
    .DW (DATA_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push_w),
    .full_i     (full_w),
    .op_o       (fr_op_w),
    .cmp_o      (fr_cmp_w),
    .ar_o       (fr_ar_w),
    .ai_o       (fr_ai_w),
    .br_o       (fr_br_w),
    .bi_o       (fr_bi_w)
  );

  assign q_in_w = {fr_op_w, fr_cmp_w, fr_ar_w, fr_ai_w, fr_br_w, fr_bi_w};

  // The queue absorbs transactions that arrive while a divide occupies the back end.
  cau_fifo #(
    .WIDTH (QW),
    .DEPTH (cau_pkg::QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .data_i  (q_in_w),
    .full_o  (full_w),
    .pop_i   (pop_w),
    .empty_o (empty_w),
    .data_o  (q_out_w)
  );

  assign {bk_op_bits_w, bk_cmp_w, bk_ar_w, bk_ai_w, bk_br_w, bk_bi_w} = q_out_w;

  // The back end forms products, sums, quotients and saturation, and holds the result
  // in an output register that holds while the receiver stalls; the queue then stops once s1 is full.
  cau_back #(
    .DW (DATA_WIDTH),
    .FB (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (!empty_w),
    .pop_o       (pop_w),
    .op_i        (cau_pkg::op_e'(bk_op_bits_w)),
    .cmp_i       (bk_cmp_w),
    .ar_i        (bk_ar_w),
    .ai_i        (bk_ai_w),
    .br_i        (bk_br_w),
    .bi_i        (bk_bi_w),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- design/cau_front.sv -----
// Front part: input register, operation decode and compare evaluation.
module cau_front #(
  parameter int DW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cau_pkg::in_t       in_data_i,
  output logic               push_o,
  input  logic               full_i,
  output cau_pkg::op_e       op_o,
  output logic               cmp_o,
  output logic signed [DW-1:0] ar_o,
  output logic signed [DW-1:0] ai_o,
  output logic signed [DW-1:0] br_o,
  output logic signed [DW-1:0] bi_o
);

  logic signed [DW-1:0] ar_w, ai_w, br_w, bi_w;
  logic                 eq_w, cmp_w, load_w;
  cau_pkg::op_e         op_w;

  logic                 fr_valid_q, fr_valid_d;
  cau_pkg::op_e         fr_op_q;
  logic                 fr_cmp_q;
  logic signed [DW-1:0] fr_ar_q, fr_ai_q, fr_br_q, fr_bi_q;

  // Operands are taken as DW-bit two's complement numbers.
  if (DW <= cau_pkg::FieldW) begin : g_narrow
    assign ar_w = in_data_i.a_re[DW-1:0];
    assign ai_w = in_data_i.a_im[DW-1:0];
    assign br_w = in_data_i.b_re[DW-1:0];
    assign bi_w = in_data_i.b_im[DW-1:0];
  end else begin : g_wide
    assign ar_w = {{(DW-cau_pkg::FieldW){in_data_i.a_re[cau_pkg::FieldW-1]}}, in_data_i.a_re};
    assign ai_w = {{(DW-cau_pkg::FieldW){in_data_i.a_im[cau_pkg::FieldW-1]}}, in_data_i.a_im};
    assign br_w = {{(DW-cau_pkg::FieldW){in_data_i.b_re[cau_pkg::FieldW-1]}}, in_data_i.b_re};
    assign bi_w = {{(DW-cau_pkg::FieldW){in_data_i.b_im[cau_pkg::FieldW-1]}}, in_data_i.b_im};
  end

  assign eq_w = (ar_w == br_w) && (ai_w == bi_w);

  always_comb begin
    op_w  = cau_pkg::OP_NONE;
    cmp_w = 1'b0;
    unique case (in_data_i.func)
      cau_pkg::FUNC_ADD: op_w = cau_pkg::OP_ADD;
      cau_pkg::FUNC_SUB: op_w = cau_pkg::OP_SUB;
      cau_pkg::FUNC_MUL: op_w = cau_pkg::OP_MUL;
      cau_pkg::FUNC_DIV: op_w = cau_pkg::OP_DIV;
      cau_pkg::FUNC_EQ: begin
        op_w  = cau_pkg::OP_CMP;
        cmp_w = eq_w;
      end
      cau_pkg::FUNC_NE: begin
        op_w  = cau_pkg::OP_CMP;
        cmp_w = !eq_w;
      end
      default: op_w = cau_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o = fr_valid_q && full_i;
  assign push_o     = fr_valid_q && !full_i;
  assign load_w     = in_valid_i && !in_stall_o;

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (load_w) begin
      fr_valid_d = 1'b1;
    end else if (push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_w) begin
      fr_op_q  <= op_w;
      fr_cmp_q <= cmp_w;
      fr_ar_q  <= ar_w;
      fr_ai_q  <= ai_w;
      fr_br_q  <= br_w;
      fr_bi_q  <= bi_w;
    end
  end

  assign op_o  = fr_op_q;
  assign cmp_o = fr_cmp_q;
  assign ar_o  = fr_ar_q;
  assign ai_o  = fr_ai_q;
  assign br_o  = fr_br_q;
  assign bi_o  = fr_bi_q;

endmodule

// ----- design/cau_fifo.sv -----
// Small register queue between the front and the back part.
module cau_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/cau_back.sv -----
// Back part: product stage, result formation, bit-serial divider and output register.
module cau_back #(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 pop_o,
  input  cau_pkg::op_e         op_i,
  input  logic                 cmp_i,
  input  logic signed [DW-1:0] ar_i,
  input  logic signed [DW-1:0] ai_i,
  input  logic signed [DW-1:0] br_i,
  input  logic signed [DW-1:0] bi_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cau_pkg::out_t        out_data_o
);

  localparam int PW = 2 * DW;
  localparam int NW = PW + FB;
  localparam int CW = $clog2(NW + 1);

  // Clamp a sign and magnitude to DW bits; the top bit of the result is the flag.
  function automatic logic [DW:0] clamp_f(input logic neg, input logic [PW:0] mag);
    logic [PW:0] maxp;
    logic [PW:0] ngv;
    maxp = {{(PW-DW+2){1'b0}}, {(DW-1){1'b1}}};
    ngv  = '0 - mag;
    if (!neg) begin
      if (mag > maxp) return {1'b1, maxp[DW-1:0]};
      return {1'b0, mag[DW-1:0]};
    end
    if (mag > maxp + (PW+1)'(1)) return {1'b1, 1'b1, {(DW-1){1'b0}}};
    return {1'b0, ngv[DW-1:0]};
  endfunction

  // Product stage.
  logic                 s1_valid_q, s1_valid_d;
  cau_pkg::op_e         s1_op_q;
  logic                 s1_cmp_q;
  logic signed [DW-1:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_bb_q, p_cc_q;

  // Divider.
  logic            dv_busy_q, dv_busy_d;
  logic [CW-1:0]   dv_cnt_q;
  logic [PW-1:0]   dv_den_q;
  logic [NW-1:0]   dv_num_re_q, dv_num_im_q;
  logic [PW-1:0]   dv_rem_re_q, dv_rem_im_q;
  logic [DW:0]     dv_quo_re_q, dv_quo_im_q;
  logic            dv_ovf_re_q, dv_ovf_im_q, dv_neg_re_q, dv_neg_im_q;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic [DW-1:0]   out_re_q, out_im_q;
  logic            out_cmp_q, out_dz_q, out_sat_q;

  logic signed [PW:0] sum_re_w, sum_im_w, den_s_w;
  logic [PW:0]        mag_re_w, mag_im_w;
  logic               neg_re_w, neg_im_w;
  logic [PW-1:0]      den_w;
  logic signed [DW:0] as_re_w, as_im_w;
  logic [DW:0]        as_abs_re_w, as_abs_im_w;
  logic [PW:0]        as_mag_re_w, as_mag_im_w;
  logic [DW:0]        cl_re_w, cl_im_w, dv_cl_re_w, dv_cl_im_w;
  logic [DW-1:0]      fin_re_w, fin_im_w;
  logic               fin_cmp_w, fin_dz_w, fin_sat_w;
  logic               out_free_w, dv_done_w, dv_write_w, s1_is_div_w;
  logic               s1_fin_w, s1_to_div_w, s1_free_w;
  logic [PW:0]        r2_re_w, r2_im_w;
  logic               bit_re_w, bit_im_w;
  logic [PW:0]        dv_mag_re_w, dv_mag_im_w;

  // Sums of the cross products: multiply subtracts in the real part, divide in the other.
  always_comb begin
    den_s_w = (PW+1)'(p_bb_q) + (PW+1)'(p_cc_q);
    den_w   = den_s_w[PW-1:0];
    if (s1_op_q == cau_pkg::OP_MUL) begin
      sum_re_w = (PW+1)'(p_rr_q) - (PW+1)'(p_ii_q);
      sum_im_w = (PW+1)'(p_ir_q) + (PW+1)'(p_ri_q);
    end else begin
      sum_re_w = (PW+1)'(p_rr_q) + (PW+1)'(p_ii_q);
      sum_im_w = (PW+1)'(p_ir_q) - (PW+1)'(p_ri_q);
    end
    neg_re_w = sum_re_w[PW];
    neg_im_w = sum_im_w[PW];
    mag_re_w = neg_re_w ? '0 - sum_re_w : sum_re_w;
    mag_im_w = neg_im_w ? '0 - sum_im_w : sum_im_w;
  end

  // The magnitude is formed at DW+1 bits and only then widened.
  always_comb begin
    if (s1_op_q == cau_pkg::OP_SUB) begin
      as_re_w = (DW+1)'(s1_ar_q) - (DW+1)'(s1_br_q);
      as_im_w = (DW+1)'(s1_ai_q) - (DW+1)'(s1_bi_q);
    end else begin
      as_re_w = (DW+1)'(s1_ar_q) + (DW+1)'(s1_br_q);
      as_im_w = (DW+1)'(s1_ai_q) + (DW+1)'(s1_bi_q);
    end
    as_abs_re_w = as_re_w[DW] ? '0 - as_re_w : as_re_w;
    as_abs_im_w = as_im_w[DW] ? '0 - as_im_w : as_im_w;
    as_mag_re_w = (PW+1)'(as_abs_re_w);
    as_mag_im_w = (PW+1)'(as_abs_im_w);
  end

  always_comb begin
    fin_re_w  = '0;
    fin_im_w  = '0;
    fin_cmp_w = 1'b0;
    fin_dz_w  = 1'b0;
    fin_sat_w = 1'b0;
    cl_re_w   = '0;
    cl_im_w   = '0;
    unique case (s1_op_q) inside
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        cl_re_w   = clamp_f(as_re_w[DW], as_mag_re_w);
        cl_im_w   = clamp_f(as_im_w[DW], as_mag_im_w);
        fin_re_w  = cl_re_w[DW-1:0];
        fin_im_w  = cl_im_w[DW-1:0];
        fin_sat_w = cl_re_w[DW] | cl_im_w[DW];
      end
      cau_pkg::OP_MUL: begin
        cl_re_w   = clamp_f(neg_re_w, mag_re_w >> FB);
        cl_im_w   = clamp_f(neg_im_w, mag_im_w >> FB);
        fin_re_w  = cl_re_w[DW-1:0];
        fin_im_w  = cl_im_w[DW-1:0];
        fin_sat_w = cl_re_w[DW] | cl_im_w[DW];
      end
      cau_pkg::OP_DIV: fin_dz_w  = 1'b1;
      cau_pkg::OP_CMP: fin_cmp_w = s1_cmp_q;
      default: fin_cmp_w = 1'b0;
    endcase
  end

  // Flow control.
  assign out_free_w  = !out_valid_q || !out_stall_i;
  assign dv_done_w   = dv_busy_q && (dv_cnt_q == '0);
  assign dv_write_w  = dv_done_w && out_free_w;
  assign s1_is_div_w = (s1_op_q == cau_pkg::OP_DIV) && (den_w != '0);
  assign s1_fin_w    = s1_valid_q && !s1_is_div_w && !dv_busy_q && out_free_w;
  assign s1_to_div_w = s1_valid_q && s1_is_div_w && !dv_busy_q;
  assign s1_free_w   = !s1_valid_q || s1_fin_w || s1_to_div_w;
  assign pop_o       = valid_i && s1_free_w;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_fin_w || s1_to_div_w) begin
      s1_valid_d = 1'b0;
    end
    dv_busy_d   = s1_to_div_w || (dv_busy_q && !dv_write_w);
    out_valid_d = dv_write_w || s1_fin_w || (out_valid_q && out_stall_i);
  end

  // One restoring division step per cycle on both parts.
  always_comb begin
    r2_re_w  = {dv_rem_re_q, dv_num_re_q[NW-1]};
    r2_im_w  = {dv_rem_im_q, dv_num_im_q[NW-1]};
    bit_re_w = r2_re_w >= {1'b0, dv_den_q};
    bit_im_w = r2_im_w >= {1'b0, dv_den_q};
    dv_mag_re_w = dv_ovf_re_q ? '1 : (PW+1)'(dv_quo_re_q);
    dv_mag_im_w = dv_ovf_im_q ? '1 : (PW+1)'(dv_quo_im_q);
    dv_cl_re_w  = clamp_f(dv_neg_re_q, dv_mag_re_w);
    dv_cl_im_w  = clamp_f(dv_neg_im_q, dv_mag_im_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      dv_busy_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      dv_busy_q   <= dv_busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_op_q  <= op_i;
      s1_cmp_q <= cmp_i;
      s1_ar_q  <= ar_i;
      s1_ai_q  <= ai_i;
      s1_br_q  <= br_i;
      s1_bi_q  <= bi_i;
      p_rr_q   <= PW'(ar_i) * PW'(br_i);
      p_ii_q   <= PW'(ai_i) * PW'(bi_i);
      p_ir_q   <= PW'(ai_i) * PW'(br_i);
      p_ri_q   <= PW'(ar_i) * PW'(bi_i);
      p_bb_q   <= PW'(br_i) * PW'(br_i);
      p_cc_q   <= PW'(bi_i) * PW'(bi_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_to_div_w) begin
      dv_cnt_q    <= CW'(NW);
      dv_den_q    <= den_w;
      dv_num_re_q <= NW'(mag_re_w[PW-1:0]) << FB;
      dv_num_im_q <= NW'(mag_im_w[PW-1:0]) << FB;
      dv_rem_re_q <= '0;
      dv_rem_im_q <= '0;
      dv_quo_re_q <= '0;
      dv_quo_im_q <= '0;
      dv_ovf_re_q <= 1'b0;
      dv_ovf_im_q <= 1'b0;
      dv_neg_re_q <= neg_re_w;
      dv_neg_im_q <= neg_im_w;
    end else if (dv_busy_q && (dv_cnt_q != '0)) begin
      dv_cnt_q    <= dv_cnt_q - CW'(1);
      dv_num_re_q <= dv_num_re_q << 1;
      dv_num_im_q <= dv_num_im_q << 1;
      dv_rem_re_q <= bit_re_w ? PW'(r2_re_w - {1'b0, dv_den_q}) : r2_re_w[PW-1:0];
      dv_rem_im_q <= bit_im_w ? PW'(r2_im_w - {1'b0, dv_den_q}) : r2_im_w[PW-1:0];
      dv_quo_re_q <= {dv_quo_re_q[DW-1:0], bit_re_w};
      dv_quo_im_q <= {dv_quo_im_q[DW-1:0], bit_im_w};
      dv_ovf_re_q <= dv_ovf_re_q | dv_quo_re_q[DW];
      dv_ovf_im_q <= dv_ovf_im_q | dv_quo_im_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_write_w) begin
      out_re_q  <= dv_cl_re_w[DW-1:0];
      out_im_q  <= dv_cl_im_w[DW-1:0];
      out_cmp_q <= 1'b0;
      out_dz_q  <= 1'b0;
      out_sat_q <= dv_cl_re_w[DW] | dv_cl_im_w[DW];
    end else if (s1_fin_w) begin
      out_re_q  <= fin_re_w;
      out_im_q  <= fin_im_w;
      out_cmp_q <= fin_cmp_w;
      out_dz_q  <= fin_dz_w;
      out_sat_q <= fin_sat_w;
    end
  end

  // Result parts are sign-extended or cut to the field width.
  if (DW >= cau_pkg::FieldW) begin : g_out_cut
    assign out_data_o.res_re = out_re_q[cau_pkg::FieldW-1:0];
    assign out_data_o.res_im = out_im_q[cau_pkg::FieldW-1:0];
  end else begin : g_out_ext
    assign out_data_o.res_re = {{(cau_pkg::FieldW-DW){out_re_q[DW-1]}}, out_re_q};
    assign out_data_o.res_im = {{(cau_pkg::FieldW-DW){out_im_q[DW-1]}}, out_im_q};
  end

  assign out_data_o.compare_true = out_cmp_q;
  assign out_data_o.div_by_zero  = out_dz_q;
  assign out_data_o.saturated    = out_sat_q;
  assign out_valid_o             = out_valid_q;

endmodule
